/* hw/rtl/csts_pkg.sv */
// Package for the chunked sparse tile store: sizes, codes and shared types.
// No dependencies; imported by every module of the block.
package csts_pkg;

  localparam int MAX_CHUNKS      = 64;
  localparam int MAX_CHUNK_SHIFT = 4;
  localparam int TILE_BITS       = 8;

  localparam int CHUNK_IDX_W  = $clog2(MAX_CHUNKS);
  localparam int OFF_W        = 2 * MAX_CHUNK_SHIFT;
  localparam int STORE_ADDR_W = CHUNK_IDX_W + OFF_W;
  localparam int STORE_DEPTH  = MAX_CHUNKS << OFF_W;
  localparam int SH_W         = $clog2(MAX_CHUNK_SHIFT + 1) > 3 ?
                                $clog2(MAX_CHUNK_SHIFT + 1) : 3;

  localparam int CNT_W   = 7;
  localparam int LIN_W   = 2 * CNT_W;
  localparam int IDX_W   = 3 * CNT_W;
  localparam int COORD_W = 32;
  localparam int VAL_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNALLOC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK   = 3'd4;

  typedef struct packed {
    logic [2:0]       chunk_shift;
    logic [CNT_W-1:0] count_x;
    logic [CNT_W-1:0] count_y;
    logic [CNT_W-1:0] count_z;
    logic [VAL_W-1:0] blank_value;
  } cfg_t;

  typedef struct packed {
    logic                   op;
    logic                   oor;
    logic [CHUNK_IDX_W-1:0] idx;
    logic [OFF_W-1:0]       off;
    logic [TILE_BITS-1:0]   wval;
  } cmd_t;

endpackage

/* hw/rtl/csts_front.sv */
// Front end: takes an item, splits coordinates, range-checks and forms the chunk index.
// Depends on csts_pkg; pushes classified commands into csts_cmd_fifo.
module csts_front (
  input  logic                         clk,
  input  logic                         rst,
  input  csts_pkg::cfg_t               cfg,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op,
  input  logic [csts_pkg::COORD_W-1:0] tile_x,
  input  logic [csts_pkg::COORD_W-1:0] tile_y,
  input  logic [csts_pkg::COORD_W-1:0] tile_z,
  input  logic [csts_pkg::VAL_W-1:0]   write_value,
  input  logic                         fifo_full,
  output logic                         push,
  output csts_pkg::cmd_t               push_cmd
);
  import csts_pkg::*;

  logic               a_valid;
  logic               a_op;
  logic [COORD_W-1:0] a_x, a_y, a_z;
  logic [VAL_W-1:0]   a_wv;

  logic               b_valid;
  logic               b_op;
  logic               b_oor;
  logic [LIN_W-1:0]   b_lin;
  logic [CNT_W-1:0]   b_cx;
  logic [OFF_W-1:0]   b_off;
  logic [VAL_W-1:0]   b_wv;

  logic [SH_W-1:0]            sh;
  logic [MAX_CHUNK_SHIFT-1:0] mask, rx, ry;
  logic [COORD_W-1:0]         cx, cy;
  logic                       in_range;
  logic [LIN_W-1:0]           lin;
  logic [OFF_W-1:0]           off;
  logic [IDX_W-1:0]           idx;
  logic                       accept, b_ready, a_move;

  assign busy    = a_valid;
  assign accept  = start && !a_valid;
  assign b_ready = !b_valid || !fifo_full;
  assign a_move  = a_valid && b_ready;

  always_comb begin
    if (cfg.chunk_shift == '0) begin
      sh = SH_W'(1);
    end else if (32'(cfg.chunk_shift) > MAX_CHUNK_SHIFT) begin
      sh = SH_W'(MAX_CHUNK_SHIFT);
    end else begin
      sh = SH_W'(cfg.chunk_shift);
    end
    mask     = MAX_CHUNK_SHIFT'((1 << sh) - 1);
    rx       = a_x[MAX_CHUNK_SHIFT-1:0] & mask;
    ry       = a_y[MAX_CHUNK_SHIFT-1:0] & mask;
    off      = (OFF_W'(ry) << sh) | OFF_W'(rx);
    cx       = a_x >> sh;
    cy       = a_y >> sh;
    in_range = (cx < COORD_W'(cfg.count_x)) && (cy < COORD_W'(cfg.count_y)) &&
               (a_z < COORD_W'(cfg.count_z));
    lin      = LIN_W'(a_z[CNT_W-1:0]) * LIN_W'(cfg.count_y) + LIN_W'(cy[CNT_W-1:0]);
  end

  always_comb begin
    idx           = IDX_W'(b_lin) * IDX_W'(cfg.count_x) + IDX_W'(b_cx);
    push          = b_valid && !fifo_full;
    push_cmd.op   = b_op;
    push_cmd.oor  = b_oor || (idx >= IDX_W'(MAX_CHUNKS));
    push_cmd.idx  = idx[CHUNK_IDX_W-1:0];
    push_cmd.off  = b_off;
    push_cmd.wval = TILE_BITS'(b_wv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_valid <= 1'b1;
      end else if (push) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op <= op;
      a_x  <= tile_x;
      a_y  <= tile_y;
      a_z  <= tile_z;
      a_wv <= write_value;
    end
    if (a_move) begin
      b_op  <= a_op;
      b_oor <= !in_range;
      b_lin <= lin;
      b_cx  <= cx[CNT_W-1:0];
      b_off <= off;
      b_wv  <= a_wv;
    end
  end

endmodule

/* hw/rtl/csts_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
// Depends on csts_pkg for the command type.
module csts_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csts_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output csts_pkg::cmd_t head,
  output logic           empty
);
  import csts_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("command queue underflow");

endmodule

/* hw/rtl/csts_back.sv */
// Back end: executes commands against the chunk valid bits and the tile memory.
// Depends on csts_pkg; pops commands from csts_cmd_fifo and drives the result ports.
module csts_back (
  input  logic                       clk,
  input  logic                       rst,
  input  csts_pkg::cfg_t             cfg,
  input  logic                       empty,
  input  csts_pkg::cmd_t             head,
  output logic                       pop,
  output logic                       done,
  output logic [csts_pkg::VAL_W-1:0] read_value,
  output logic [1:0]                 status
);
  import csts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } state_t;

  state_t state, state_next;
  cmd_t   cur, cur_next;
  logic [OFF_W-1:0]      fill_cnt, fill_cnt_next;
  logic [MAX_CHUNKS-1:0] chunk_valid;
  logic                  set_valid;

  logic [TILE_BITS-1:0]    mem [STORE_DEPTH];
  logic [TILE_BITS-1:0]    mem_q;
  logic                    we;
  logic [STORE_ADDR_W-1:0] waddr, raddr;
  logic [TILE_BITS-1:0]    wdata;

  logic             emit;
  logic [VAL_W-1:0] emit_val;
  logic [1:0]       emit_st;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    fill_cnt_next = fill_cnt;
    pop           = 1'b0;
    set_valid     = 1'b0;
    we            = 1'b0;
    waddr         = {head.idx, head.off};
    wdata         = head.wval;
    raddr         = {head.idx, head.off};
    emit          = 1'b0;
    emit_val      = '0;
    emit_st       = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          cur_next = head;
          if (head.oor) begin
            emit    = 1'b1;
            emit_st = ST_RANGE;
          end else if (head.op == OP_READ) begin
            if (!chunk_valid[head.idx]) begin
              emit    = 1'b1;
              emit_st = ST_UNALLOC;
            end else begin
              state_next = S_READ;
            end
          end else if (chunk_valid[head.idx]) begin
            we   = 1'b1;
            emit = 1'b1;
          end else begin
            state_next    = S_FILL;
            fill_cnt_next = '0;
          end
        end
      end
      S_READ: begin
        emit       = 1'b1;
        emit_val   = VAL_W'(mem_q);
        state_next = S_IDLE;
      end
      S_FILL: begin
        we            = 1'b1;
        waddr         = {cur.idx, fill_cnt};
        wdata         = (fill_cnt == cur.off) ? cur.wval : TILE_BITS'(cfg.blank_value);
        fill_cnt_next = fill_cnt + OFF_W'(1);
        if (fill_cnt == '1) begin
          set_valid  = 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chunk_valid <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (set_valid) begin
        chunk_valid[cur.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    fill_cnt <= fill_cnt_next;
    if (emit) begin
      read_value <= emit_val;
      status     <= emit_st;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (done && status == ST_OK)) else $error("read result missing");
  a_busy_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pop) else $error("pop while busy");
  a_fill_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && fill_cnt == '1) |=> (chunk_valid[cur.idx] && done))
    else $error("chunk not allocated after fill");

endmodule

/* hw/rtl/chunked_sparse_tile_store_unit.sv */
// Top level of the chunked sparse tile store: configuration registers and the
// front end, command queue and back end. Depends on csts_pkg and all csts_* modules.
//
// Usage: drive op, tile_x/y/z and write_value and raise start; the item is
// taken at a clock edge where start is high and busy is low. Each item gives
// one result: done is high for exactly one cycle with read_value and status.
// The receiver cannot stall; results must be taken when done is high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, so a transfer completes whenever cfg_valid is high. Indexes
// beyond the register list are ignored. Write only while no item is in flight.
// Path: each item passes the front end's two stages and the queue; the back end
// then pops it and registers done with the result. Reads of allocated chunks
// first pass S_READ for the memory read. The first write into a chunk sweeps
// all 256 tiles of its region through the single write port in S_FILL.
// Flow: the front end takes no new item while busy, that is while its first stage
// holds one; the two-entry queue lets the front keep taking items during a fill.
// Reset: all chunks unallocated, registers to shift 4, counts 4, blank 0.
module chunked_sparse_tile_store_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [csts_pkg::COORD_W-1:0]    tile_x,
  input  logic [csts_pkg::COORD_W-1:0]    tile_y,
  input  logic [csts_pkg::COORD_W-1:0]    tile_z,
  input  logic [csts_pkg::VAL_W-1:0]      write_value,
  output logic                            done,
  output logic [csts_pkg::VAL_W-1:0]      read_value,
  output logic [1:0]                      status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csts_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head;
  logic push, pop, fifo_full, fifo_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_shift <= 3'd4;
      cfg.count_x     <= CNT_W'(4);
      cfg.count_y     <= CNT_W'(4);
      cfg.count_z     <= CNT_W'(4);
      cfg.blank_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHIFT:   cfg.chunk_shift <= cfg_data[2:0];
        CFG_COUNT_X: cfg.count_x     <= cfg_data[CNT_W-1:0];
        CFG_COUNT_Y: cfg.count_y     <= cfg_data[CNT_W-1:0];
        CFG_COUNT_Z: cfg.count_z     <= cfg_data[CNT_W-1:0];
        CFG_BLANK:   cfg.blank_value <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  csts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .tile_z      (tile_z),
    .write_value (write_value),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  csts_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty)
  );

  csts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .empty      (fifo_empty),
    .head       (head),
    .pop        (pop),
    .done       (done),
    .read_value (read_value),
    .status     (status)
  );

endmodule
